>>> rtl/sol_pkg.sv
// shared types, constants and register map of the split-operator line propagator
// depends on nothing; the core, sol_cmac and the bench import it
package sol_pkg;

   localparam int DEF_MAX_LINE = 64;
   localparam int DW           = 16;
   localparam int FRAC         = 14;
   localparam int CSR_AW       = 5;
   localparam int CSR_DW       = 32;

   // register indexes (byte address bits 4..2)
   localparam logic [2:0] REG_DIAG_RE    = 3'd0;
   localparam logic [2:0] REG_DIAG_IM    = 3'd1;
   localparam logic [2:0] REG_OFFDIAG_RE = 3'd2;
   localparam logic [2:0] REG_OFFDIAG_IM = 3'd3;
   localparam logic [2:0] REG_FULL_STEP  = 3'd4;

   localparam logic signed [DW-1:0] DIAG_RE_RST = 16'sd16384;

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;

   typedef logic signed [DW-1:0] sample_type;

   // operands of one complex multiply-accumulate: d*s + o*t
   typedef struct packed {
      logic       valid;
      logic       last;
      sample_type s_re;
      sample_type s_im;
      sample_type t_re;
      sample_type t_im;
      sample_type d_re;
      sample_type d_im;
      sample_type o_re;
      sample_type o_im;
   } op_type;

   typedef struct packed {
      logic       valid;
      logic       last;
      logic       clip;
      sample_type re;
      sample_type im;
   } rsp_type;

endpackage

>>> rtl/split_operator_line_propagator_core.sv
// split-operator line propagator: kinetic line pass and potential phase multiply, Q1.14
// path: a potential request runs through stage 1, product, sum and output registers; a line
// runs from its line_end request through emit state, store read and the same registers, then
// one result per cycle while rsp_stall is low; one request per cycle while loading and the
// pipeline moves, but requests stall while a line is emitted
// reset (synchronous): fill count, sequencer and pipeline valids cleared, registers to defaults
module split_operator_line_propagator_core
   import sol_pkg::*;
#(
   parameter int MAX_LINE = DEF_MAX_LINE
) (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_func,
   input  logic signed [15:0] req_wave_re,
   input  logic signed [15:0] req_wave_im,
   input  logic signed [15:0] req_phase_re,
   input  logic signed [15:0] req_phase_im,
   input  logic              req_line_end,
   // result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic signed [15:0] rsp_new_re,
   output logic signed [15:0] rsp_new_im,
   output logic              rsp_run_end,
   output logic              rsp_clipped,
   // register port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
   localparam int CW = $clog2(MAX_LINE + 1);

   // configuration registers
   sample_type diag_re_ff;
   sample_type diag_im_ff;
   sample_type offdiag_re_ff;
   sample_type offdiag_im_ff;
   logic       full_step_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;

   // sequencer
   state_type  state_ff;
   state_type  state_in;
   logic [CW-1:0] fill_ff;
   logic [CW-1:0] fill_in;
   logic [CW-1:0] fill_after;
   logic [CW-1:0] n_m1;
   logic [AW-1:0] j_ff;
   logic [AW-1:0] j_in;
   logic [AW-1:0] nb;

   logic req_acc;
   logic kin_acc;
   logic pot_acc;
   logic store_en;
   logic issue;
   logic issue_last;
   logic up;
   logic advance;

   // stage 1: line store read data or a potential request
   logic       s1_v_ff;
   logic       s1_pot_ff;
   logic       s1_last_ff;
   sample_type s1_wave_re_ff;
   sample_type s1_wave_im_ff;
   sample_type s1_phase_re_ff;
   sample_type s1_phase_im_ff;
   logic [2*DW-1:0] rd_self;
   logic [2*DW-1:0] rd_nb;

   op_type  op;
   rsp_type rsp;

   // ---------------------------------------------------------------- registers

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         diag_re_ff    <= DIAG_RE_RST;
         diag_im_ff    <= '0;
         offdiag_re_ff <= '0;
         offdiag_im_ff <= '0;
         full_step_ff  <= 1'b0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_DIAG_RE:    diag_re_ff    <= csr_pwdata[DW-1:0];
            REG_DIAG_IM:    diag_im_ff    <= csr_pwdata[DW-1:0];
            REG_OFFDIAG_RE: offdiag_re_ff <= csr_pwdata[DW-1:0];
            REG_OFFDIAG_IM: offdiag_im_ff <= csr_pwdata[DW-1:0];
            REG_FULL_STEP:  full_step_ff  <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_DIAG_RE:    csr_prdata = {{(CSR_DW-DW){1'b0}}, diag_re_ff};
         REG_DIAG_IM:    csr_prdata = {{(CSR_DW-DW){1'b0}}, diag_im_ff};
         REG_OFFDIAG_RE: csr_prdata = {{(CSR_DW-DW){1'b0}}, offdiag_re_ff};
         REG_OFFDIAG_IM: csr_prdata = {{(CSR_DW-DW){1'b0}}, offdiag_im_ff};
         REG_FULL_STEP:  csr_prdata = {{(CSR_DW-1){1'b0}}, full_step_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- request side

   // requests are only taken while idle and the pipeline can move, so the
   // line store is never written and read in the same pass (no forwarding)
   assign req_stall = (state_ff != ST_IDLE) || !advance;
   assign req_acc   = req_valid && !req_stall;
   assign kin_acc   = req_acc && !req_func;
   assign pot_acc   = req_acc && req_func;

   // a sample arriving on a full store is dropped, its line_end still counts
   assign store_en   = kin_acc && (fill_ff < CW'(MAX_LINE));
   assign fill_after = store_en ? fill_ff + CW'(1) : fill_ff;

   // ---------------------------------------------------------------- line sequencer

   assign issue      = (state_ff == ST_EMIT) && advance;
   assign n_m1       = fill_ff - CW'(1);
   assign issue_last = (CW'(j_ff) == n_m1);

   // half step: even samples couple upward; full step: odd samples do
   assign up = (j_ff[0] == full_step_ff);

   // periodic neighbour
   always_comb begin
      if (up) begin
         nb = issue_last ? '0 : AW'(j_ff + 1'b1);
      end else begin
         nb = (j_ff == '0) ? n_m1[AW-1:0] : AW'(j_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         j_ff     <= j_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      j_in     = j_ff;
      case (state_ff)
         ST_IDLE: begin
            if (kin_acc) begin
               fill_in = fill_after;
               if (req_line_end) begin
                  state_in = ST_EMIT;
                  j_in     = '0;
               end
            end
         end
         ST_EMIT: begin
            if (advance) begin
               if (issue_last) begin
                  state_in = ST_IDLE;
                  fill_in  = '0;
                  j_in     = '0;
               end else begin
                  j_in = AW'(j_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------- line store

   sol_line_mem #(
      .DEPTH (MAX_LINE),
      .AW    (AW),
      .WW    (2*DW)
   ) u_mem (
      .clock     (clock),
      .wr_en     (store_en),
      .wr_addr   (fill_ff[AW-1:0]),
      .wr_data   ({req_wave_im, req_wave_re}),
      .rd_en     (issue),
      .rd_addr_a (j_ff),
      .rd_addr_b (nb),
      .rd_data_a (rd_self),
      .rd_data_b (rd_nb)
   );

   // ---------------------------------------------------------------- stage 1

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (advance) begin
         s1_v_ff <= issue || pot_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_pot_ff      <= pot_acc;
         s1_last_ff     <= pot_acc || issue_last;
         s1_wave_re_ff  <= req_wave_re;
         s1_wave_im_ff  <= req_wave_im;
         s1_phase_re_ff <= req_phase_re;
         s1_phase_im_ff <= req_phase_im;
      end
   end

   // potential request rides the same datapath: phase as diagonal, no coupling
   always_comb begin
      op.valid = s1_v_ff;
      op.last  = s1_last_ff;
      if (s1_pot_ff) begin
         op.s_re = s1_wave_re_ff;
         op.s_im = s1_wave_im_ff;
         op.t_re = '0;
         op.t_im = '0;
         op.d_re = s1_phase_re_ff;
         op.d_im = s1_phase_im_ff;
         op.o_re = '0;
         op.o_im = '0;
      end else begin
         op.s_re = rd_self[DW-1:0];
         op.s_im = rd_self[2*DW-1:DW];
         op.t_re = rd_nb[DW-1:0];
         op.t_im = rd_nb[2*DW-1:DW];
         op.d_re = diag_re_ff;
         op.d_im = diag_im_ff;
         op.o_re = offdiag_re_ff;
         op.o_im = offdiag_im_ff;
      end
   end

   // ---------------------------------------------------------------- arithmetic and output

   sol_cmac u_cmac (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .rsp_stall (rsp_stall),
      .advance   (advance),
      .rsp       (rsp)
   );

   assign rsp_valid   = rsp.valid;
   assign rsp_new_re  = rsp.re;
   assign rsp_new_im  = rsp.im;
   assign rsp_run_end = rsp.last;
   assign rsp_clipped = rsp.clip;

   // ---------------------------------------------------------------- checks

   // the store never holds more than a full line
   assert property (@(posedge clock) disable iff (reset) fill_ff <= CW'(MAX_LINE))
      else $error("fill count beyond line length");

   // while emitting, the read index stays inside the held line
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (CW'(j_ff) < fill_ff))
      else $error("emit index outside held line");

   // a kinetic request marked line_end always starts emission
   assert property (@(posedge clock) disable iff (reset)
      (kin_acc && req_line_end) |=> (state_ff == ST_EMIT))
      else $error("line end did not start emission");

   // no read of the line store while the store is being filled
   assert property (@(posedge clock) disable iff (reset) !(store_en && issue))
      else $error("line store write and read overlap");

endmodule

>>> rtl/sol_line_mem.sv
// line sample store: one write port, two registered read ports
// depends on nothing but its parameters
module sol_line_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = 6,
   parameter int WW    = 32
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [WW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr_a,
   input  logic [AW-1:0] rd_addr_b,
   output logic [WW-1:0] rd_data_a,
   output logic [WW-1:0] rd_data_b
);

   logic [WW-1:0] mem_ff [DEPTH];
   logic [WW-1:0] rd_a_ff;
   logic [WW-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read data holds while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> rtl/sol_cmac.sv
// complex multiply-accumulate pipeline with rounding, saturation and output register
// depends on sol_pkg
module sol_cmac
   import sol_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  op_type  op,
   input  logic    rsp_stall,
   output logic    advance,
   output rsp_type rsp
);

   localparam int PW = 2*DW;
   localparam int SW = PW + 2;
   localparam int RW = SW + 1;

   logic                 prod_v_ff;
   logic                 prod_last_ff;
   logic signed [PW-1:0] prod_ff [8];
   logic signed [PW-1:0] prod_in [8];

   logic                 sum_v_ff;
   logic                 sum_last_ff;
   logic signed [SW-1:0] sum_re_ff;
   logic signed [SW-1:0] sum_im_ff;
   logic signed [SW-1:0] sum_re_in;
   logic signed [SW-1:0] sum_im_in;

   rsp_type              out_ff;
   logic [DW:0]          rnd_re;
   logic [DW:0]          rnd_im;

   // round half up to Q1.14, then clamp; top bit flags clamping
   function automatic logic [DW:0] round_sat(input logic signed [SW-1:0] acc);
      logic signed [RW-1:0] r;
      logic signed [RW-1:0] q;
      logic [DW:0]          res;
      r = RW'(acc) + RW'(signed'(1 <<< (FRAC-1)));
      q = r >>> FRAC;
      if (q > RW'(signed'(2**(DW-1) - 1))) begin
         res = {1'b1, 1'b0, {(DW-1){1'b1}}};
      end else if (q < -RW'(signed'(2**(DW-1)))) begin
         res = {1'b1, 1'b1, {(DW-1){1'b0}}};
      end else begin
         res = {1'b0, q[DW-1:0]};
      end
      return res;
   endfunction

   assign advance = !out_ff.valid || !rsp_stall;

   always_comb begin
      prod_in[0] = PW'(op.d_re) * PW'(op.s_re);
      prod_in[1] = PW'(op.d_im) * PW'(op.s_im);
      prod_in[2] = PW'(op.o_re) * PW'(op.t_re);
      prod_in[3] = PW'(op.o_im) * PW'(op.t_im);
      prod_in[4] = PW'(op.d_re) * PW'(op.s_im);
      prod_in[5] = PW'(op.d_im) * PW'(op.s_re);
      prod_in[6] = PW'(op.o_re) * PW'(op.t_im);
      prod_in[7] = PW'(op.o_im) * PW'(op.t_re);
   end

   assign sum_re_in = SW'(prod_ff[0]) - SW'(prod_ff[1]) + SW'(prod_ff[2]) - SW'(prod_ff[3]);
   assign sum_im_in = SW'(prod_ff[4]) + SW'(prod_ff[5]) + SW'(prod_ff[6]) + SW'(prod_ff[7]);

   assign rnd_re = round_sat(sum_re_ff);
   assign rnd_im = round_sat(sum_im_ff);

   // valids cleared by reset, data only moves with the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff    <= 1'b0;
         sum_v_ff     <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         prod_v_ff    <= op.valid;
         sum_v_ff     <= prod_v_ff;
         out_ff.valid <= sum_v_ff;
      end
      if (advance) begin
         prod_last_ff <= op.last;
         for (int i = 0; i < 8; i++) begin
            prod_ff[i] <= prod_in[i];
         end
         sum_last_ff <= prod_last_ff;
         sum_re_ff   <= sum_re_in;
         sum_im_ff   <= sum_im_in;
         out_ff.last <= sum_last_ff;
         out_ff.clip <= rnd_re[DW] | rnd_im[DW];
         out_ff.re   <= rnd_re[DW-1:0];
         out_ff.im   <= rnd_im[DW-1:0];
      end
   end

   assign rsp = out_ff;

endmodule

>>> tb/tb_split_operator_line_propagator_core.sv
// self-checking bench for split_operator_line_propagator_core: kinetic line passes and
// potential phase multiplies against a bit-true Q1.14 predictor, with random idling
// depends on rtl/sol_pkg.sv and rtl/split_operator_line_propagator_core.sv with its submodules
module tb_split_operator_line_propagator_core
   import sol_pkg::*;
;

   localparam int CLK_PERIOD   = 10;
   localparam int LINE_CAP     = DEF_MAX_LINE;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int PHASE_ITEMS  = 18;

   localparam logic FUNC_KINETIC   = 1'b0;
   localparam logic FUNC_POTENTIAL = 1'b1;

   localparam sample_type S_MIN = 16'sh8000;
   localparam sample_type S_MAX = 16'sh7fff;
   localparam sample_type S_ONE = 16'sd16384;

   // one request as the sender holds it
   typedef struct packed {
      logic       func;
      sample_type wave_re;
      sample_type wave_im;
      sample_type phase_re;
      sample_type phase_im;
      logic       line_end;
   } request_type;

   // one propagated sample as the block should return it
   typedef struct packed {
      sample_type re;
      sample_type im;
      logic       run_end;
      logic       clipped;
   } propagated_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic       req_valid    = 1'b0;
   logic       req_stall;
   logic       req_func     = FUNC_KINETIC;
   sample_type req_wave_re  = '0;
   sample_type req_wave_im  = '0;
   sample_type req_phase_re = '0;
   sample_type req_phase_im = '0;
   logic       req_line_end = 1'b0;

   // result channel
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_new_re;
   sample_type rsp_new_im;
   logic       rsp_run_end;
   logic       rsp_clipped;

   // register port
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr   = '0;
   logic [CSR_DW-1:0] csr_pwdata  = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   // requests waiting for the sender, and samples the block still owes us
   request_type    pending_requests[$];
   propagated_type predicted_samples[$];
   int          queued_count   = 0;
   int          accepted_count = 0;
   int          result_count   = 0;
   int          mismatch_count = 0;
   int          cycle_count    = 0;

   // predictor copy of the coefficient registers
   sample_type coef_diag_re    = DIAG_RE_RST;
   sample_type coef_diag_im    = '0;
   sample_type coef_offdiag_re = '0;
   sample_type coef_offdiag_im = '0;
   logic       coef_full_step  = 1'b0;

   // predictor copy of the line buffer
   sample_type line_re[LINE_CAP];
   sample_type line_im[LINE_CAP];
   int         line_fill = 0;

   // sender burst shaping and receiver stall pattern
   request_type held_req   = '0;
   int       burst_left = 0;
   int       gap_left   = 0;
   int       stall_hold = 0;

   split_operator_line_propagator_core u_top (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_wave_re  (req_wave_re),
      .req_wave_im  (req_wave_im),
      .req_phase_re (req_phase_re),
      .req_phase_im (req_phase_im),
      .req_line_end (req_line_end),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_new_re   (rsp_new_re),
      .rsp_new_im   (rsp_new_im),
      .rsp_run_end  (rsp_run_end),
      .rsp_clipped  (rsp_clipped),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready)
   );

   always #(CLK_PERIOD/2) clock = ~clock;

   // ---------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------

   // exact sum rounded once to Q1.14, ties toward plus infinity, then saturated
   function automatic sample_type round_q14(input longint acc, inout logic clip);
      longint q;
      q = (acc + 64'sd8192) >>> FRAC;
      if (q > 32767) begin
         clip = 1'b1;
         return S_MAX;
      end
      if (q < -32768) begin
         clip = 1'b1;
         return S_MIN;
      end
      return sample_type'(q);
   endfunction

   // d*s + o*t over complex Q1.14 operands, products kept exact
   function automatic propagated_type complex_mac(input sample_type d_re, d_im, s_re, s_im,
                                                  input sample_type o_re, o_im, t_re, t_im,
                                                  input logic last);
      propagated_type res;
      longint      acc_re;
      longint      acc_im;
      logic        clip;
      clip   = 1'b0;
      acc_re = longint'(d_re) * longint'(s_re) - longint'(d_im) * longint'(s_im)
             + longint'(o_re) * longint'(t_re) - longint'(o_im) * longint'(t_im);
      acc_im = longint'(d_re) * longint'(s_im) + longint'(d_im) * longint'(s_re)
             + longint'(o_re) * longint'(t_im) + longint'(o_im) * longint'(t_re);
      res.re      = round_q14(acc_re, clip);
      res.im      = round_q14(acc_im, clip);
      res.run_end = last;
      res.clipped = clip;
      return res;
   endfunction

   // works out what one accepted request makes the block return
   task automatic propagate_request(input request_type r);
      int   n;
      int   nb;
      logic up;
      if (r.func == FUNC_POTENTIAL) begin
         // phase * wave at once, line buffer left alone, line_end ignored
         predicted_samples.push_back(complex_mac(r.phase_re, r.phase_im, r.wave_re,
                                                 r.wave_im, '0, '0, '0, '0, 1'b1));
         return;
      end
      // a sample arriving at a full buffer is dropped, its line_end still counts
      if (line_fill < LINE_CAP) begin
         line_re[line_fill] = r.wave_re;
         line_im[line_fill] = r.wave_im;
         line_fill++;
      end
      if (!r.line_end)
         return;
      n = line_fill;
      for (int j = 0; j < n; j++) begin
         // half step: even points couple upward; full step: odd points do
         up = ((j % 2) == 0) == (coef_full_step == 1'b0);
         if (up)
            nb = (j + 1 == n) ? 0 : j + 1;
         else
            nb = (j == 0) ? n - 1 : j - 1;
         predicted_samples.push_back(complex_mac(coef_diag_re, coef_diag_im,
                                                 line_re[j], line_im[j],
                                                 coef_offdiag_re, coef_offdiag_im,
                                                 line_re[nb], line_im[nb], j + 1 == n));
      end
      line_fill = 0;
   endtask

   // ---------------------------------------------------------------------------------
   // sender: bursts of random length, random gaps between them
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_requests
      logic fire;
      logic nxt_valid;
      fire      = req_valid && !req_stall;
      nxt_valid = req_valid && !fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (fire) begin
            propagate_request(held_req);
            accepted_count++;
         end
         if (!nxt_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_requests.size() > 0) begin
               held_req  = pending_requests.pop_front();
               nxt_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; a third of them follow on with no gap at all
                  burst_left = $urandom_range(0, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         // payload only moves when a new request is loaded, so a stalled one holds
         req_valid    <= nxt_valid;
         req_func     <= held_req.func;
         req_wave_re  <= held_req.wave_re;
         req_wave_im  <= held_req.wave_im;
         req_phase_re <= held_req.phase_re;
         req_phase_im <= held_req.phase_im;
         req_line_end <= held_req.line_end;
      end
   end

   // ---------------------------------------------------------------------------------
   // receiver: short stalls, scattered stalls and long free stretches
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin
      if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         case ($urandom_range(0, 5))
            0: begin
               rsp_stall  <= 1'b1;
               stall_hold <= $urandom_range(0, 7);
            end
            1: begin
               rsp_stall  <= 1'b0;
               stall_hold <= $urandom_range(20, 40);
            end
            default: begin
               rsp_stall  <= ($urandom_range(0, 2) == 0);
               stall_hold <= $urandom_range(0, 3);
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------------------
   // monitor: every accepted result against the oldest prediction
   // ---------------------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      propagated_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_samples.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("result %0d unexpected: re %0d im %0d run_end %0b clipped %0b",
                        result_count, rsp_new_re, rsp_new_im, rsp_run_end, rsp_clipped);
         end else begin
            want = predicted_samples.pop_front();
            if (rsp_new_re !== want.re || rsp_new_im !== want.im ||
                rsp_run_end !== want.run_end || rsp_clipped !== want.clipped) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result %0d: expected re %0d im %0d run_end %0b clipped %0b, %s",
                           result_count, want.re, want.im, want.run_end, want.clipped,
                           $sformatf("got re %0d im %0d run_end %0b clipped %0b",
                                     rsp_new_re, rsp_new_im, rsp_run_end, rsp_clipped));
            end
         end
         result_count++;
      end
   end

   // watchdog, far beyond the slowest correct run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------

   // random sample leaning on the corners now and then
   function automatic sample_type rand_sample();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 9))
         0:       return S_MIN;
         1:       return S_MAX;
         2:       return '0;
         3:       return sample_type'($signed(r[3:0]));
         default: return r[15:0];
      endcase
   endfunction

   task automatic add_request(input logic func, input sample_type wr, wi, pr, pi,
                              input logic le);
      request_type r;
      r.func     = func;
      r.wave_re  = wr;
      r.wave_im  = wi;
      r.phase_re = pr;
      r.phase_im = pi;
      r.line_end = le;
      pending_requests.push_back(r);
      queued_count++;
   endtask

   // a kinetic line of n samples with the odd potential request slipped in between
   task automatic add_line(input int n);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(0, 9) == 0)
            add_request(FUNC_POTENTIAL, rand_sample(), rand_sample(), rand_sample(),
                        rand_sample(), 1'($urandom_range(0, 1)));
         add_request(FUNC_KINETIC, rand_sample(), rand_sample(), rand_sample(),
                     rand_sample(), k == n - 1);
      end
   endtask

   // mostly short lines, some lone potential requests, rarely a line near or over capacity
   task automatic add_random_traffic(input int budget);
      int start;
      int pick;
      start = queued_count;
      while (queued_count - start < budget) begin
         pick = $urandom_range(0, 19);
         if (pick < 3)
            add_request(FUNC_POTENTIAL, rand_sample(), rand_sample(), rand_sample(),
                        rand_sample(), 1'($urandom_range(0, 1)));
         else if (pick == 3)
            add_line($urandom_range(LINE_CAP - 4, LINE_CAP + 4));
         else
            add_line($urandom_range(1, 8));
      end
   endtask

   // hold until every request is taken and every result is back, then let the pipe settle
   task automatic wait_drained();
      while (accepted_count != queued_count) @(posedge clock);
      while (predicted_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // setup cycle, access cycle, then release
   task automatic write_register(input logic [2:0] idx, input logic [CSR_DW-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_DIAG_RE:    coef_diag_re    = value[15:0];
         REG_DIAG_IM:    coef_diag_im    = value[15:0];
         REG_OFFDIAG_RE: coef_offdiag_re = value[15:0];
         REG_OFFDIAG_IM: coef_offdiag_im = value[15:0];
         REG_FULL_STEP:  coef_full_step  = value[0];
         default: ;
      endcase
   endtask

   task automatic set_coefficients(input sample_type d_re, d_im, o_re, o_im,
                                   input logic full);
      write_register(REG_DIAG_RE, {{16{d_re[15]}}, d_re});
      write_register(REG_DIAG_IM, {{16{d_im[15]}}, d_im});
      write_register(REG_OFFDIAG_RE, {{16{o_re[15]}}, o_re});
      write_register(REG_OFFDIAG_IM, {{16{o_im[15]}}, o_im});
      write_register(REG_FULL_STEP, {31'd0, full});
   endtask

   // ---------------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------------
   initial begin : stimulus
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset coefficients: corner products, rounding ties, a lone-sample line
      add_request(FUNC_POTENTIAL, S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
      add_request(FUNC_POTENTIAL, S_MAX, S_MAX, S_MAX, S_MIN, 1'b1);
      add_request(FUNC_POTENTIAL, 16'sd1, '0, 16'sd8192, '0, 1'b0);
      add_request(FUNC_POTENTIAL, -16'sd1, '0, 16'sd8192, '0, 1'b0);
      add_request(FUNC_KINETIC, S_MAX, S_MIN, S_MIN, S_MAX, 1'b1);
      wait_drained();

      // extreme coefficients, half step: saturation, wrap-around, ignored line_end
      set_coefficients(S_MAX, S_MIN, S_MIN, S_MAX, 1'b0);
      add_request(FUNC_KINETIC, S_MIN, S_MIN, S_MAX, S_MAX, 1'b1);
      add_request(FUNC_KINETIC, S_MAX, S_MAX, '0, '0, 1'b0);
      add_request(FUNC_KINETIC, S_MIN, S_MAX, '0, '0, 1'b0);
      add_request(FUNC_POTENTIAL, S_MAX, S_MIN, S_MIN, S_MAX, 1'b1);
      add_request(FUNC_KINETIC, '0, S_MIN, '0, '0, 1'b1);
      add_request(FUNC_KINETIC, 16'sd1, -16'sd1, '0, '0, 1'b0);
      add_request(FUNC_KINETIC, -16'sd2, 16'sd2, '0, '0, 1'b1);
      wait_drained();

      // full step parity on even and odd line lengths
      set_coefficients(S_ONE, '0, -S_ONE, 16'sd8192, 1'b1);
      add_line(4);
      add_line(3);
      add_line(2);
      wait_drained();

      // random phases, each under its own coefficient set
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: set_coefficients(S_ONE, '0, 16'sd8192, -16'sd4096, 1'b0);
            1: set_coefficients(rand_sample(), rand_sample(), rand_sample(),
                                rand_sample(), 1'b1);
            2: set_coefficients(S_MIN, S_MAX, S_MAX, S_MIN, 1'b0);
            3: set_coefficients(16'sd11585, 16'sd11585, -16'sd3000, 16'sd2500, 1'b1);
            4: set_coefficients(rand_sample(), rand_sample(), rand_sample(),
                                rand_sample(), 1'($urandom_range(0, 1)));
            default: set_coefficients('0, '0, S_ONE, '0, 1'($urandom_range(0, 1)));
         endcase
         // exactly full, and overfull so that samples get dropped
         if (phase == 2) begin
            add_line(LINE_CAP);
            add_line(LINE_CAP + 2);
         end
         add_random_traffic(PHASE_ITEMS);
         wait_drained();
      end

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
